// ===== rtl/pelco_d_response_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Pelco-D response parser
// Immediate-implication and next-cycle-implication forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef PELCO_D_RESPONSE_PARSER_MACROS_SVH
`define PELCO_D_RESPONSE_PARSER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PDRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PDRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pdrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrp_pkg
// Types and constants shared by the Pelco-D response parser and its channels.
// ----------------------------------------------------------------------------
package pdrp_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [1:0]  t_kind;
    typedef logic [15:0] t_pos;
    typedef logic [12:0] t_hfov;

    // Frame phase, one-hot: hunting, then the six bytes after sync.
    typedef enum logic [6:0] {
        PH_HUNT  = 7'b000_0001,
        PH_ADDR  = 7'b000_0010,
        PH_RESP1 = 7'b000_0100,
        PH_RESP2 = 7'b000_1000,
        PH_DATA1 = 7'b001_0000,
        PH_DATA2 = 7'b010_0000,
        PH_CSUM  = 7'b100_0000
    } t_phase;

    localparam t_byte SYNC_BYTE  = 8'hFF;
    localparam t_byte RESP_ZOOM  = 8'hA7;
    localparam t_byte RESP_FOCUS = 8'h63;

    localparam t_kind KIND_OTHER = 2'd0;
    localparam t_kind KIND_ZOOM  = 2'd1;
    localparam t_kind KIND_FOCUS = 2'd2;

    // Zoom travel is normalized to 2^14; hfov = wide - span * pos / 2^14.
    localparam int    ZOOM_SHIFT = 14;
    localparam t_pos  ZOOM_FULL  = 16'h4000;
    localparam t_hfov HFOV_WIDE  = 13'd6370;
    localparam t_hfov HFOV_SPAN  = 13'd6140;
    localparam t_hfov HFOV_TELE  = 13'd230;

endpackage

// ===== rtl/pdrp_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrp_rx_if
// Received-byte channel: valid/ready handshake carrying one serial byte.
// ----------------------------------------------------------------------------
interface pdrp_rx_if;

    logic            valid;
    logic            ready;
    pdrp_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

// ===== rtl/pdrp_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrp_res_if
// Parsed-response channel: valid/ready handshake carrying one decoded frame.
// ----------------------------------------------------------------------------
interface pdrp_res_if;

    logic            valid;
    logic            ready;
    pdrp_pkg::t_kind frame_kind;
    pdrp_pkg::t_pos  position;
    pdrp_pkg::t_hfov hfov_centideg;

    modport source (output valid, output frame_kind, output position,
                    output hfov_centideg, input ready);
    modport sink   (input valid, input frame_kind, input position,
                    input hfov_centideg, output ready);

endinterface

// ===== rtl/pelco_d_response_parser.sv =====
// Bytes pass the input register and parser; any result is in the result register.
// Throughput: one byte per cycle; while a result waits downstream the input
//   register can still take one byte, then input stalls until the result leaves.
// Reset (i_rst_n low, synchronous): parser back to hunting for sync, checksum
//   cleared, both item registers emptied; frame bytes are not reset.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pelco_d_response_parser
// Byte-serial Pelco-D response frame parser: sync hunt, checksum, decode of
// zoom (with horizontal field of view) and focus position responses.
// ----------------------------------------------------------------------------
`include "pelco_d_response_parser_macros.svh"

module pelco_d_response_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pdrp_rx_if.sink           i_rx,
    pdrp_res_if.source        o_res
);
    import pdrp_pkg::*;

    // ------------------------------------------------------------------
    // Input register: one received byte waiting for the parser stage.
    // ------------------------------------------------------------------
    logic   r_in_vld;
    t_byte  r_in_byte;

    // Parser state
    t_phase r_phase, n_phase;
    t_byte  r_sum, n_sum;
    // Frame store: response 2, data 1, data 2 (no reset, always written
    // in the same frame before the checksum byte reads them)
    t_byte  r_resp, r_data_hi, r_data_lo;

    // Result register
    logic   r_out_vld;
    t_kind  r_out_kind;
    t_pos   r_out_pos;
    t_hfov  r_out_hfov;

    // Stage control: the parser stage steps when its byte can leave, i.e.
    // the result register is empty or being drained this cycle.
    logic   w_adv;
    logic   w_step;
    logic   w_emit;

    // Decode
    t_pos         w_pos;
    logic [14:0]  w_clip;
    logic [27:0]  w_prod;
    t_hfov        w_hfov;
    t_kind        w_kind;
    t_pos         w_res_pos;
    t_hfov        w_res_hfov;

    assign w_adv      = !r_out_vld || o_res.ready;
    assign w_step     = r_in_vld && w_adv;
    assign i_rx.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Frame sequencer. Bytes 1..5 are summed mod 256; the sixth is the
    // checksum. A bad checksum drops the frame with no resync inside it.
    // A sync byte inside a frame is ordinary data.
    // ------------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        w_emit  = 1'b0;
        if (w_step) begin
            case (r_phase)
                PH_HUNT: begin
                    if (r_in_byte == SYNC_BYTE) begin
                        n_phase = PH_ADDR;
                        n_sum   = '0;
                    end
                end
                PH_ADDR: begin
                    n_sum   = r_sum + r_in_byte;
                    n_phase = PH_RESP1;
                end
                PH_RESP1: begin
                    n_sum   = r_sum + r_in_byte;
                    n_phase = PH_RESP2;
                end
                PH_RESP2: begin
                    n_sum   = r_sum + r_in_byte;
                    n_phase = PH_DATA1;
                end
                PH_DATA1: begin
                    n_sum   = r_sum + r_in_byte;
                    n_phase = PH_DATA2;
                end
                PH_DATA2: begin
                    n_sum   = r_sum + r_in_byte;
                    n_phase = PH_CSUM;
                end
                PH_CSUM: begin
                    n_phase = PH_HUNT;
                    w_emit  = (r_in_byte == r_sum);
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_phase == PH_RESP2) begin
            r_resp <= r_in_byte;
        end
        if (w_step && r_phase == PH_DATA1) begin
            r_data_hi <= r_in_byte;
        end
        if (w_step && r_phase == PH_DATA2) begin
            r_data_lo <= r_in_byte;
        end
    end

    // ------------------------------------------------------------------
    // Response decode. The field of view clips the zoom position at full
    // scale, scales the span by pos / 2^14 (floor) and subtracts it from
    // the wide-end value; the result stays in 230..6370.
    // ------------------------------------------------------------------
    assign w_pos  = {r_data_hi, r_data_lo};
    assign w_clip = (w_pos > ZOOM_FULL) ? ZOOM_FULL[14:0] : w_pos[14:0];
    assign w_prod = 28'(HFOV_SPAN) * 28'(w_clip);
    assign w_hfov = HFOV_WIDE - 13'(w_prod >> ZOOM_SHIFT);

    always_comb begin
        case (r_resp)
            RESP_ZOOM: begin
                w_kind     = KIND_ZOOM;
                w_res_pos  = w_pos;
                w_res_hfov = w_hfov;
            end
            RESP_FOCUS: begin
                w_kind     = KIND_FOCUS;
                w_res_pos  = w_pos;
                w_res_hfov = '0;
            end
            default: begin
                w_kind     = KIND_OTHER;
                w_res_pos  = '0;
                w_res_hfov = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register: holds a result until the sink takes it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_step && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out_kind <= w_kind;
            r_out_pos  <= w_res_pos;
            r_out_hfov <= w_res_hfov;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.frame_kind    = r_out_kind;
    assign o_res.position      = r_out_pos;
    assign o_res.hfov_centideg = r_out_hfov;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PDRP_ASSERT_NEXT(a_emit_only_on_csum, i_clk, i_rst_n, w_step && w_emit,
        r_out_vld && $past(r_phase) == PH_CSUM, "result without checksum byte")
    `PDRP_ASSERT_NEXT(a_csum_back_to_hunt, i_clk, i_rst_n, w_step && r_phase == PH_CSUM,
        r_phase == PH_HUNT, "no return to hunt after checksum")
    `PDRP_ASSERT_NOW(a_hfov_zero_not_zoom, i_clk, i_rst_n,
        r_out_vld && r_out_kind != KIND_ZOOM, r_out_hfov == '0,
        "field of view set on non-zoom result")
    `PDRP_ASSERT_NOW(a_hfov_range, i_clk, i_rst_n, r_out_vld && r_out_kind == KIND_ZOOM,
        r_out_hfov >= HFOV_TELE && r_out_hfov <= HFOV_WIDE, "field of view out of range")
    `PDRP_ASSERT_NOW(a_other_pos_zero, i_clk, i_rst_n,
        r_out_vld && r_out_kind == KIND_OTHER, r_out_pos == '0,
        "position set on other response")

endmodule
